>>> src/lpd_pkg.sv
`default_nettype none
package lpd_pkg;

  localparam int unsigned LEN_W = 24;
  localparam int unsigned HDR_BYTES = 4;

  localparam logic [1:0] HDR_CNT_LAST = 2'(HDR_BYTES - 1);
  localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HDR_BYTES);
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd65536;

  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       err;
  } lpd_result_t;

endpackage
`default_nettype wire

>>> src/lpd_core.sv
`default_nettype none
module lpd_core
  import lpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire len_t        cfg_wr_data,
  input  wire logic        acc,
  input  wire logic [7:0]  in_byte,
  output lpd_result_t      res
);

  len_t       max_len_r;
  logic [1:0] hdr_cnt_r, hdr_cnt_nxt;
  len_t       hdr_shift_r, hdr_shift_nxt;
  logic       in_body_r, in_body_nxt;
  len_t       body_left_r, body_left_nxt;

  logic       too_large;
  logic       too_small;
  len_t       len_low;

  assign len_low   = {hdr_shift_r[15:0], in_byte};
  assign too_large = (hdr_shift_r[23:16] != 8'd0) || (len_low > max_len_r);
  assign too_small = len_low < HDR_LEN;

  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    hdr_shift_nxt = hdr_shift_r;
    in_body_nxt   = in_body_r;
    body_left_nxt = body_left_r;
    res.data      = in_byte;
    res.first     = 1'b0;
    res.last      = 1'b0;
    res.err       = 1'b0;
    if (in_body_r) begin
      if (body_left_r <= len_t'(1)) begin
        body_left_nxt = '0;
        in_body_nxt   = 1'b0;
        res.last      = 1'b1;
      end else begin
        body_left_nxt = body_left_r - len_t'(1);
      end
    end else begin
      res.first = (hdr_cnt_r == 2'd0);
      if (hdr_cnt_r != HDR_CNT_LAST) begin
        hdr_shift_nxt = {hdr_shift_r[15:0], in_byte};
        hdr_cnt_nxt   = hdr_cnt_r + 2'd1;
      end else begin
        hdr_cnt_nxt   = 2'd0;
        hdr_shift_nxt = '0;
        if (too_large || too_small) begin
          res.err = 1'b1;
        end else if (len_low == HDR_LEN) begin
          res.last = 1'b1;
        end else begin
          in_body_nxt   = 1'b1;
          body_left_nxt = len_low - HDR_LEN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LEN_RESET;
      hdr_cnt_r   <= 2'd0;
      hdr_shift_r <= '0;
      in_body_r   <= 1'b0;
      body_left_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      if (acc) begin
        hdr_cnt_r   <= hdr_cnt_nxt;
        hdr_shift_r <= hdr_shift_nxt;
        in_body_r   <= in_body_nxt;
        body_left_r <= body_left_nxt;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/lpd_skid.sv
`default_nettype none
module lpd_skid
  import lpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_stall,
  input  wire lpd_result_t up_data,
  output logic             dn_valid,
  input  wire logic        dn_stall,
  output lpd_result_t      dn_data
);

  logic        main_valid_r;
  lpd_result_t main_r;
  logic        skid_valid_r;
  lpd_result_t skid_r;
  logic        up_acc;
  logic        dn_acc;

  assign up_stall = skid_valid_r;
  assign up_acc   = up_valid && !skid_valid_r;
  assign dn_acc   = main_valid_r && !dn_stall;
  assign dn_valid = main_valid_r;
  assign dn_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (dn_acc) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (up_acc) begin
      if (!main_valid_r || dn_acc) begin
        main_r       <= up_data;
        main_valid_r <= 1'b1;
      end else begin
        skid_r       <= up_data;
        skid_valid_r <= 1'b1;
      end
    end else if (dn_acc) begin
      main_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> src/length_prefixed_stream_deframer.sv
// An accepted byte's result is registered in the output buffer (main entry, or skid entry
// while the main entry is stalled). Throughput: one byte per cycle while in_stall is low;
// header parsing and the length check are combinational. A two-entry output buffer lets
// input transfers continue while one result waits; in_stall rises only when both entries
// are full. Reset is synchronous and active low: it empties the output buffer, returns the
// parser to header reading and sets the maximum message length to 65536.
`default_nettype none
module length_prefixed_stream_deframer
  import lpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_message_first,
  output logic             out_message_last,
  output logic             out_length_error
);

  lpd_result_t res;
  lpd_result_t dn_data;
  logic        acc;

  assign acc = in_valid && !in_stall;

  lpd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .in_byte     (in_byte),
    .res         (res)
  );

  lpd_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (res),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (dn_data)
  );

  assign out_byte          = dn_data.data;
  assign out_message_first = dn_data.first;
  assign out_message_last  = dn_data.last;
  assign out_length_error  = dn_data.err;

endmodule
`default_nettype wire

>>> src/lpd_checker.sv
`default_nettype none
module lpd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_message_first,
  input wire logic       out_message_last,
  input wire logic       out_length_error
);

  // A result marks at most one of first, last and error.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_message_first, out_message_last, out_length_error}) <= 1)
    else $error("more than one of first, last and error set on one transfer");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side stalls only while a result is already waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result changed");

endmodule

bind length_prefixed_stream_deframer lpd_checker u_lpd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte          (out_byte),
  .out_message_first (out_message_first),
  .out_message_last  (out_message_last),
  .out_length_error  (out_length_error)
);
`default_nettype wire
